[hw/rtl/rhpc_pkg.sv]
// Shared constants and types for the rolling hash pattern counter.
`default_nettype none
package rhpc_pkg;

  localparam int MAX_TEXT = 1024;
  localparam int ADDR_W   = $clog2(MAX_TEXT);
  localparam int LEN_W    = $clog2(MAX_TEXT + 2);
  localparam int HASH_W   = 64;
  localparam int HALF_W   = HASH_W / 2;
  localparam int CODE_W   = 7;
  localparam int COUNT_W  = 11;

  localparam logic [HASH_W-1:0]  HASH_MULT = 64'd911382323;
  localparam logic [HASH_W-1:0]  CODE_BIAS = 64'd96;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 11'd2047;

  // tuser code on the input stream
  localparam logic REQ_TEXT    = 1'b0;
  localparam logic REQ_PATTERN = 1'b1;

  typedef logic [HASH_W-1:0] hash_t;
  typedef logic [LEN_W-1:0]  len_t;

  // request into the shared multiplier
  typedef struct packed {
    logic  start;
    hash_t a;
    hash_t b;
  } mul_req_t;

  // answer from the shared multiplier
  typedef struct packed {
    logic  done;
    hash_t p;
  } mul_rsp_t;

endpackage
`default_nettype wire

[hw/rtl/rhpc_mul.sv]
// Iterative 64x64 mod 2^64 multiplier built on one 32x32 multiplier.
`default_nettype none
module rhpc_mul (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rhpc_pkg::mul_req_t req,
  output      rhpc_pkg::mul_rsp_t rsp
);
  import rhpc_pkg::*;

  localparam logic [1:0] STEP_LL = 2'd0;
  localparam logic [1:0] STEP_LH = 2'd1;
  localparam logic [1:0] STEP_HL = 2'd2;

  hash_t             a;
  hash_t             b;
  hash_t             acc;
  logic [1:0]        step;
  logic              busy;
  logic              done;
  logic [HALF_W-1:0] op_x;
  logic [HALF_W-1:0] op_y;
  hash_t             prod;

  always_comb begin
    unique case (step)
      STEP_LL: begin
        op_x = a[HALF_W-1:0];
        op_y = b[HALF_W-1:0];
      end
      STEP_LH: begin
        op_x = a[HALF_W-1:0];
        op_y = b[HASH_W-1:HALF_W];
      end
      default: begin
        op_x = a[HASH_W-1:HALF_W];
        op_y = b[HALF_W-1:0];
      end
    endcase
    prod = op_x * op_y;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= STEP_LL;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= STEP_LL;
      end else if (busy) begin
        if (step == STEP_HL) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 2'd1;
      end
    end
  end

  // cross terms only reach the upper half modulo 2^64
  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.a;
      b <= req.b;
    end else if (busy) begin
      if (step == STEP_LL) begin
        acc <= prod;
      end else begin
        acc[HASH_W-1:HALF_W] <= acc[HASH_W-1:HALF_W] + prod[HALF_W-1:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.p    = acc;

endmodule
`default_nettype wire

[hw/rtl/rolling_hash_pattern_counter.sv]
// Top level: character intake, prefix hash store and window scan sequencer.
// Text character: one multiply (three partial products on the shared multiplier);
// pattern character: two multiplies; the last one adds a scan with one multiply
// per window, and the result is shown once the output is free. A result not yet taken holds
// the block. One item at a time. Reset (rst, synchronous) empties text and pattern;
// the hash store is not cleared, only entries below the text length are used.
`default_nettype none
module rolling_hash_pattern_counter (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,  // [6:0] char_code
  input  wire logic        s_axis_tuser,  // [0] req_type
  input  wire logic        s_axis_tlast,  // last
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata   // [10:0] match_count, [11] pattern_too_long,
                                          // [12] text_overflow
);
  import rhpc_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_TMUL  = 9'b000000010,
    S_PH    = 9'b000000100,
    S_PP    = 9'b000001000,
    S_CHK   = 9'b000010000,
    S_RD    = 9'b000100000,
    S_MST   = 9'b001000000,
    S_MWAIT = 9'b010000000,
    S_RES   = 9'b100000000
  } state_t;

  localparam len_t LEN_LIMIT = LEN_W'(MAX_TEXT);
  localparam len_t LEN_SAT   = LEN_W'(MAX_TEXT + 1);

  state_t   state;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  hash_t              hash_mem [MAX_TEXT];
  hash_t              qa;
  hash_t              qb;
  hash_t              last_hash;
  len_t               text_len;
  logic               text_complete;
  logic               overflow;
  hash_t              pat_hash;
  hash_t              pat_power;
  len_t               pat_len;
  hash_t              val;
  logic               fin;
  len_t               r;
  logic [COUNT_W-1:0] cnt;
  logic [COUNT_W-1:0] res_cnt;
  logic               res_long;

  logic               accept;
  logic               clear_text;
  len_t               len_eff;
  hash_t              in_val;
  hash_t              sum;
  hash_t              window;
  len_t               lm1;
  logic               hit;
  logic [COUNT_W-1:0] cnt_next;

  rhpc_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (mreq),
    .rsp (mrsp)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign clear_text    = text_complete;
  assign len_eff       = clear_text ? '0 : text_len;
  assign in_val        = {{(HASH_W-CODE_W){1'b0}}, s_axis_tdata[CODE_W-1:0]} - CODE_BIAS;
  assign sum           = mrsp.p + val;
  assign lm1           = r - pat_len;
  assign window        = qa - ((r >= pat_len) ? mrsp.p : '0);
  assign hit           = (window == pat_hash);
  assign cnt_next      = (hit && cnt < COUNT_MAX) ? cnt + 1'b1 : cnt;

  always_comb begin
    mreq.start = 1'b0;
    mreq.a     = pat_hash;
    mreq.b     = HASH_MULT;
    unique case (state) inside
      S_IDLE: begin
        if (accept) begin
          if (s_axis_tuser == REQ_TEXT) begin
            mreq.start = (len_eff < LEN_LIMIT);
            mreq.a     = (len_eff == '0) ? '0 : last_hash;
          end else begin
            mreq.start = 1'b1;
          end
        end
      end
      S_PH: begin
        mreq.start = mrsp.done;
        mreq.a     = pat_power;
      end
      S_MST: begin
        mreq.start = 1'b1;
        mreq.a     = qb;
        mreq.b     = pat_power;
      end
      S_TMUL, S_PP, S_CHK, S_RD, S_MWAIT, S_RES: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      text_len      <= '0;
      text_complete <= 1'b0;
      overflow      <= 1'b0;
      pat_hash      <= '0;
      pat_power     <= 64'd1;
      pat_len       <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (s_axis_tuser == REQ_TEXT) begin
              if (clear_text) begin
                text_len <= '0;
                overflow <= 1'b0;
              end
              if (len_eff < LEN_LIMIT) begin
                text_complete <= 1'b0;
                state         <= S_TMUL;
              end else begin
                overflow      <= 1'b1;
                text_complete <= s_axis_tlast;
              end
            end else begin
              state <= S_PH;
            end
          end
        end
        S_TMUL: begin
          if (mrsp.done) begin
            text_len      <= text_len + 1'b1;
            text_complete <= fin;
            state         <= S_IDLE;
          end
        end
        S_PH: begin
          if (mrsp.done) begin
            pat_hash <= sum;
            state    <= S_PP;
          end
        end
        S_PP: begin
          if (mrsp.done) begin
            pat_power <= mrsp.p;
            if (pat_len < LEN_SAT) begin
              pat_len <= pat_len + 1'b1;
            end
            state <= fin ? S_CHK : S_IDLE;
          end
        end
        S_CHK: begin
          if (pat_len > text_len) begin
            res_cnt   <= '0;
            res_long  <= 1'b1;
            pat_hash  <= '0;
            pat_power <= 64'd1;
            pat_len   <= '0;
            state     <= S_RES;
          end else begin
            r     <= pat_len - 1'b1;
            cnt   <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          state <= S_MST;
        end
        S_MST: begin
          state <= S_MWAIT;
        end
        S_MWAIT: begin
          if (mrsp.done) begin
            cnt <= cnt_next;
            if (r == text_len - 1'b1) begin
              res_cnt   <= cnt_next;
              res_long  <= 1'b0;
              pat_hash  <= '0;
              pat_power <= 64'd1;
              pat_len   <= '0;
              state     <= S_RES;
            end else begin
              r     <= r + 1'b1;
              state <= S_RD;
            end
          end
        end
        S_RES: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, overflow, res_long, res_cnt};
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // item payload and last stored hash
  always_ff @(posedge clk) begin
    if (accept) begin
      val <= in_val;
      fin <= s_axis_tlast;
    end
    if (state == S_TMUL && mrsp.done) begin
      last_hash <= sum;
    end
  end

  // prefix hash store: one write port, two registered reads
  always_ff @(posedge clk) begin
    if (state == S_TMUL && mrsp.done) begin
      hash_mem[text_len[ADDR_W-1:0]] <= sum;
    end
    if (state == S_RD) begin
      qa <= hash_mem[r[ADDR_W-1:0]];
      qb <= hash_mem[lm1[ADDR_W-1:0]];
    end
  end

endmodule
`default_nettype wire
